### rtl/core/interval_range_map_assert.svh
// Assertion macros for the interval range map.
`ifndef INTERVAL_RANGE_MAP_ASSERT_SVH
`define INTERVAL_RANGE_MAP_ASSERT_SVH
`ifndef ASSERT_OFF
`define IRM_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`else
`define IRM_ASSERT(label, clk, rst_n, prop)
`endif
`endif

### rtl/core/irm_pkg.sv
package irm_pkg;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned VAL_W = 32;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic {
    FN_LOOKUP = 1'b0,
    FN_ASSIGN = 1'b1
  } func_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture request
    logic scan_rd;    // issue read of scan index
    logic scan_eval;  // evaluate returned entry
    logic decide;     // compute counts after scan
    logic mv_rd;      // read one tail entry
    logic mv_wr;      // write the tail entry read last cycle
    logic put_begin;  // write (begin, value)
    logic put_end;    // write (end, old)
    logic commit;     // update entry count
    logic out_load;   // load output register
  } irm_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;  // scan index reached entry count
    logic is_assign;
    logic empty_iv;
    logic full;
    logic mv_none;    // no tail to move
  } irm_sts_t;

endpackage

### rtl/core/irm_datapath.sv
module irm_datapath #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned IDX_W = 6,
  parameter int unsigned CNT_W = 7
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  irm_pkg::irm_cmd_t              cmd,
  output irm_pkg::irm_sts_t              sts,
  input  logic                           cfg_wr_en,
  input  logic [irm_pkg::VAL_W-1:0]      cfg_wr_data,
  input  logic                           in_func,
  input  logic [irm_pkg::KEY_W-1:0]      in_key_begin,
  input  logic [irm_pkg::KEY_W-1:0]      in_key_end,
  input  logic [irm_pkg::VAL_W-1:0]      in_new_value,
  output logic [irm_pkg::VAL_W-1:0]      res_value,
  output logic [1:0]                     res_status
);

  localparam int unsigned KW = irm_pkg::KEY_W;
  localparam int unsigned VW = irm_pkg::VAL_W;

  logic [KW-1:0] key_mem [TABLE_ENTRIES];
  logic [VW-1:0] val_mem [TABLE_ENTRIES];

  logic [VW-1:0] dflt_r;
  logic [CNT_W-1:0] count_r;
  logic func_r;
  logic [KW-1:0] kb_r, ke_r;
  logic [VW-1:0] nv_r;
  logic [CNT_W-1:0] scan_r, lo_r, hi_r;
  logic [VW-1:0] old_r, look_r;
  logic [KW-1:0] rd_key_r;
  logic [VW-1:0] rd_val_r;
  logic [CNT_W-1:0] src_r, dst_r, mv_left_r, newcnt_r;
  logic full_r;
  logic [VW-1:0] res_value_r;
  logic [1:0] res_status_r;

  // signed compare via biased keys
  logic [KW-1:0] bk, bb, be;
  assign bk = rd_key_r ^ {1'b1, {(KW-1){1'b0}}};
  assign bb = kb_r ^ {1'b1, {(KW-1){1'b0}}};
  assign be = ke_r ^ {1'b1, {(KW-1){1'b0}}};

  logic [CNT_W-1:0] removed, tail, newcnt;
  logic [CNT_W:0] newcnt_w;
  assign removed = hi_r - lo_r;
  assign tail = count_r - hi_r;
  assign newcnt_w = {1'b0, count_r} - {1'b0, removed} + (CNT_W+1)'(2);
  assign newcnt = newcnt_w[CNT_W-1:0];

  logic [CNT_W-1:0] rd_addr, wr_addr;
  logic wr_en;
  logic [KW-1:0] wr_key;
  logic [VW-1:0] wr_val;

  always_comb begin
    rd_addr = cmd.mv_rd ? src_r : scan_r;
    wr_en = cmd.mv_wr | cmd.put_begin | cmd.put_end;
    wr_addr = dst_r;
    wr_key = rd_key_r;
    wr_val = rd_val_r;
    if (cmd.put_begin) begin
      wr_addr = lo_r;
      wr_key = kb_r;
      wr_val = nv_r;
    end else if (cmd.put_end) begin
      wr_addr = lo_r + CNT_W'(1);
      wr_key = ke_r;
      wr_val = old_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_rd || cmd.mv_rd) begin
      rd_key_r <= key_mem[rd_addr[IDX_W-1:0]];
      rd_val_r <= val_mem[rd_addr[IDX_W-1:0]];
    end
    if (wr_en) begin
      key_mem[wr_addr[IDX_W-1:0]] <= wr_key;
      val_mem[wr_addr[IDX_W-1:0]] <= wr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dflt_r <= {1'b1, {(VW-1){1'b0}}};
      count_r <= '0;
    end else begin
      if (cfg_wr_en) dflt_r <= cfg_wr_data;
      if (cmd.commit) count_r <= newcnt_r;
    end
  end

  logic up_r;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      kb_r <= in_key_begin;
      ke_r <= in_key_end;
      nv_r <= in_new_value;
      scan_r <= '0;
      lo_r <= '0;
      hi_r <= '0;
      old_r <= dflt_r;
      look_r <= dflt_r;
    end
    if (cmd.scan_rd) scan_r <= scan_r + CNT_W'(1);
    if (cmd.scan_eval) begin
      if (bk <= bb) look_r <= rd_val_r;
      if (bk < bb) lo_r <= lo_r + CNT_W'(1);
      if (bk <= be) begin
        hi_r <= hi_r + CNT_W'(1);
        old_r <= rd_val_r;
      end
    end
    if (cmd.decide) begin
      full_r <= newcnt_w > (CNT_W+1)'(TABLE_ENTRIES);
      newcnt_r <= newcnt;
      mv_left_r <= tail;
      // moving down walks from the bottom, moving up from the top
      up_r <= (lo_r + CNT_W'(2)) > hi_r;
      if ((lo_r + CNT_W'(2)) > hi_r) begin
        src_r <= count_r - CNT_W'(1);
        dst_r <= count_r - removed + CNT_W'(1);
      end else begin
        src_r <= hi_r;
        dst_r <= lo_r + CNT_W'(2);
      end
    end
    if (cmd.mv_rd) begin
      mv_left_r <= mv_left_r - CNT_W'(1);
    end
    if (cmd.mv_wr) begin
      src_r <= up_r ? src_r - CNT_W'(1) : src_r + CNT_W'(1);
      dst_r <= up_r ? dst_r - CNT_W'(1) : dst_r + CNT_W'(1);
    end
    if (cmd.out_load) begin
      if (!func_r) begin
        res_value_r <= look_r;
        res_status_r <= irm_pkg::ST_DONE;
      end else begin
        res_value_r <= '0;
        if (!(bb < be)) res_status_r <= irm_pkg::ST_IGNORED;
        else if (full_r) res_status_r <= irm_pkg::ST_FULL;
        else res_status_r <= irm_pkg::ST_DONE;
      end
    end
  end

  assign sts.scan_last = (scan_r == count_r);
  assign sts.is_assign = func_r;
  assign sts.empty_iv = !(bb < be);
  assign sts.full = full_r;
  assign sts.mv_none = (mv_left_r == '0);
  assign res_value = res_value_r;
  assign res_status = res_status_r;

endmodule

### rtl/core/irm_ctrl.sv
`include "interval_range_map_assert.svh"
module irm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  output logic              busy,
  input  logic              out_free,
  output logic              out_set,
  output irm_pkg::irm_cmd_t cmd,
  input  irm_pkg::irm_sts_t sts
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SCAN  = 8'b0000_0010,
    S_EVAL  = 8'b0000_0100,
    S_DEC   = 8'b0000_1000,
    S_MVRD  = 8'b0001_0000,
    S_MVWR  = 8'b0010_0000,
    S_PUT   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic put2_r, put2_nxt;

  always_comb begin
    state_nxt = state_r;
    put2_nxt = put2_r;
    cmd = '0;
    out_set = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_last) begin
          state_nxt = S_DEC;
        end else begin
          cmd.scan_rd = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.scan_eval = 1'b1;
        state_nxt = S_SCAN;
      end
      S_DEC: begin
        cmd.decide = 1'b1;
        if (sts.is_assign && !sts.empty_iv) state_nxt = S_MVRD;
        else state_nxt = S_OUT;
      end
      S_MVRD: begin
        put2_nxt = 1'b0;
        if (sts.full) state_nxt = S_OUT;
        else if (sts.mv_none) state_nxt = S_PUT;
        else begin
          cmd.mv_rd = 1'b1;
          state_nxt = S_MVWR;
        end
      end
      S_MVWR: begin
        cmd.mv_wr = 1'b1;
        state_nxt = S_MVRD;
      end
      S_PUT: begin
        if (!put2_r) begin
          cmd.put_begin = 1'b1;
          put2_nxt = 1'b1;
        end else begin
          cmd.put_end = 1'b1;
          cmd.commit = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          out_set = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      put2_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      put2_r <= put2_nxt;
    end
  end

  `IRM_ASSERT(a_onehot, clk, rst_n, $onehot(state_r))
  `IRM_ASSERT(a_load_idle, clk, rst_n, cmd.load |-> state_r == S_IDLE)
  `IRM_ASSERT(a_wr_after_rd, clk, rst_n, cmd.mv_wr |-> $past(cmd.mv_rd))
  `IRM_ASSERT(a_commit_out, clk, rst_n, cmd.commit |=> state_r == S_OUT)

endmodule

### rtl/core/interval_range_map.sv
// Interval range map: a sorted table of up to TABLE_ENTRIES breakpoints
// (key, value), each value holding from its key up to the next key; keys
// below the first breakpoint read cfg default_value (reset 0x80000000).
// in_tdata = {new_value, key_end, key_begin} (bits 95:0), in_tuser = func
// (0 lookup at key_begin, 1 assign [key_begin,key_end) := new_value).
// Each request gives one result: out_tdata[31:0] read_value (0 on assign),
// out_tdata[33:32] status (0 done, 1 empty interval ignored, 2 table full).
// One request at a time. Each request scans every table entry, one read per
// entry through the table's read port, and an assign that fits then moves
// each tail entry (a read, then a write) and writes the two new breakpoints.
// The result register lets the next request enter while a result waits.
// No clearing pass after reset.
// default_value may only be written while no request is in progress.
module interval_range_map #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,   // default_value
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,      // key_begin, key_end, new_value
  input  logic        in_tuser,      // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata      // read_value, status, zero pad
);

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

  irm_pkg::irm_cmd_t cmd;
  irm_pkg::irm_sts_t sts;
  logic busy, out_set, in_fire, out_free;
  logic out_valid_r;
  logic [31:0] res_value;
  logic [1:0] res_status;

  assign in_tready = !busy;
  assign in_fire = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  irm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .busy(busy),
    .out_free(out_free), .out_set(out_set), .cmd(cmd), .sts(sts)
  );

  irm_datapath #(
    .TABLE_ENTRIES(TABLE_ENTRIES), .IDX_W(IDX_W), .CNT_W(CNT_W)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_func(in_tuser), .in_key_begin(in_tdata[31:0]),
    .in_key_end(in_tdata[63:32]), .in_new_value(in_tdata[95:64]),
    .res_value(res_value), .res_status(res_status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_set) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {6'd0, res_status, res_value};

endmodule

### tb/sv/tb_interval_range_map.sv
module tb_interval_range_map;

  localparam int ENTRIES = 64;

  // Signals toward the block. Every input holds a known value from time zero.
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;   // key_begin, key_end, new_value (lowest bits first)
  logic        in_tuser = 1'b0; // func
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // read_value, status, zero pad

  interval_range_map #(.TABLE_ENTRIES(ENTRIES)) dut (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  always #5 clk = ~clk;

  // Mirror of the breakpoint table, plus the queue of results it implies.
  class map_scoreboard;
    logic signed [31:0] keys[ENTRIES];
    logic signed [31:0] vals[ENTRIES];
    int                 count;
    logic signed [31:0] dflt;
    logic [31:0]        want_value[$];
    irm_pkg::status_t   want_status[$];
    int                 errors;
    int                 n_lookup, n_done, n_ignored, n_full, n_checked;

    function new();
      count = 0;
      dflt = 32'sh8000_0000;
      errors = 0;
    endfunction

    // value in force at k: last breakpoint with key <= k
    function logic signed [31:0] value_at(logic signed [31:0] k);
      logic signed [31:0] v;
      v = dflt;
      for (int i = 0; i < count; i++)
        if (keys[i] <= k) v = vals[i];
      return v;
    endfunction

    function void note_request(irm_pkg::func_t f, logic signed [31:0] kb,
                               logic signed [31:0] ke, logic signed [31:0] nv);
      logic signed [31:0] old;
      int lo, hi, ncount;
      logic signed [31:0] tk[ENTRIES];
      logic signed [31:0] tv[ENTRIES];
      if (f == irm_pkg::FN_LOOKUP) begin
        want_value.push_back(value_at(kb));
        want_status.push_back(irm_pkg::ST_DONE);
        n_lookup++;
        return;
      end
      want_value.push_back('0);
      if (kb >= ke) begin
        want_status.push_back(irm_pkg::ST_IGNORED);
        n_ignored++;
        return;
      end
      old = value_at(ke);
      lo = 0;
      while (lo < count && keys[lo] < kb) lo++;
      hi = 0;
      while (hi < count && keys[hi] <= ke) hi++;
      ncount = count - (hi - lo) + 2;
      if (ncount > ENTRIES) begin
        want_status.push_back(irm_pkg::ST_FULL);
        n_full++;
        return;
      end
      tk = keys;
      tv = vals;
      for (int i = hi; i < count; i++) begin
        keys[lo + 2 + i - hi] = tk[i];
        vals[lo + 2 + i - hi] = tv[i];
      end
      keys[lo] = kb;
      vals[lo] = nv;
      keys[lo + 1] = ke;
      vals[lo + 1] = old;
      count = ncount;
      want_status.push_back(irm_pkg::ST_DONE);
      n_done++;
    endfunction

    function void check_result(logic [39:0] d);
      logic [31:0]      ev;
      irm_pkg::status_t es;
      if (want_value.size() == 0) begin
        $error("unexpected result: read_value %0h status %0d", d[31:0], d[33:32]);
        errors++;
        return;
      end
      ev = want_value.pop_front();
      es = want_status.pop_front();
      n_checked++;
      if (d[31:0] !== ev) begin
        $error("read_value: expected %0h, got %0h", ev, d[31:0]);
        errors++;
      end
      if (d[33:32] !== es) begin
        $error("status: expected %0d, got %0d", es, d[33:32]);
        errors++;
      end
    endfunction
  endclass

  map_scoreboard sb = new();

  // Receiver stall pattern; long_hold forces a long back-pressure window.
  bit long_hold = 1'b0;
  int stall_mode = 0;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  always @(negedge clk) begin
    if (long_hold) out_tready <= 1'b0;
    else if (stall_mode == 0) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(0, 3) != 0);
  end

  int burst_left = 0;

  // Send one request; bursts of random length with random gaps between them.
  // tvalid stays up inside a burst and drops only for a gap or at wait_idle.
  task automatic send_request(irm_pkg::func_t f, logic signed [31:0] kb,
                              logic signed [31:0] ke, logic signed [31:0] nv);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser <= f;
    in_tdata <= {nv, ke, kb};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(f, kb, ke, nv);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.want_value.size() != 0) @(posedge clk);
    repeat (4 * ENTRIES + 20) @(posedge clk);
    @(negedge clk);
  endtask

  // Only written while the block holds no request.
  task automatic write_default(logic signed [31:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.dflt = v;
  endtask

  // Keys mostly from a narrow pool so intervals overlap and the table fills.
  function automatic logic signed [31:0] pick_key();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return $urandom();
      default: return $signed($urandom_range(0, 200)) - 100;
    endcase
  endfunction

  task automatic random_phase(int n);
    logic signed [31:0] a, b;
    for (int i = 0; i < n; i++) begin
      a = pick_key();
      b = pick_key();
      if ($urandom_range(0, 9) < 4) begin
        send_request(irm_pkg::FN_LOOKUP, a, $urandom(), $urandom());
      end else begin
        // mostly well-ordered intervals; some reversed or empty ones
        if ($urandom_range(0, 7) != 0 && a > b)
          send_request(irm_pkg::FN_ASSIGN, b, a, $urandom());
        else send_request(irm_pkg::FN_ASSIGN, a, b, $urandom());
      end
    end
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty table, extremes, empty interval, every operation.
    send_request(irm_pkg::FN_LOOKUP, 32'sh8000_0000, '0, '0);
    send_request(irm_pkg::FN_LOOKUP, 32'sh7fff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_request(irm_pkg::FN_ASSIGN, 5, 5, 32'h1234);
    send_request(irm_pkg::FN_ASSIGN, 9, -9, 32'h1234);
    send_request(irm_pkg::FN_ASSIGN, 32'sh8000_0000, 32'sh7fff_ffff, 32'hffff_ffff);
    send_request(irm_pkg::FN_LOOKUP, 32'sh8000_0000, '0, '0);
    send_request(irm_pkg::FN_LOOKUP, 32'sh7fff_ffff, '0, '0);
    send_request(irm_pkg::FN_ASSIGN, -10, 10, 32'h5555_aaaa);
    send_request(irm_pkg::FN_ASSIGN, 0, 20, 32'haaaa_5555);
    send_request(irm_pkg::FN_ASSIGN, -10, 20, 7);
    send_request(irm_pkg::FN_LOOKUP, -11, '0, '0);
    send_request(irm_pkg::FN_LOOKUP, -10, '0, '0);
    send_request(irm_pkg::FN_LOOKUP, 20, '0, '0);
    send_request(irm_pkg::FN_ASSIGN, 32'sh7fff_fffe, 32'sh7fff_ffff, 32'h0);
    send_request(irm_pkg::FN_LOOKUP, 32'sh7fff_fffe, '0, '0);
    // fill the table with disjoint intervals until it refuses
    for (int i = 0; i < 34; i++)
      send_request(irm_pkg::FN_ASSIGN, 1000 + 4 * i, 1002 + 4 * i, i);
    send_request(irm_pkg::FN_LOOKUP, 1005, '0, '0);
    wait_idle();

    write_default(32'sh7fff_ffff);
    send_request(irm_pkg::FN_LOOKUP, 32'sh8000_0000, '0, '0);
    stall_mode = 1;
    random_phase(250);

    // Hold the receiver off for a long stretch while requests keep coming.
    fork
      begin
        long_hold = 1'b1;
        repeat (2000) @(posedge clk);
        long_hold = 1'b0;
      end
      random_phase(20);
    join
    wait_idle();

    write_default(32'sh0000_0000);
    stall_mode = 0;
    random_phase(200);
    wait_idle();

    write_default(32'sh8000_0000);
    stall_mode = 1;
    random_phase(250);
    wait_idle();

    $display("Checked %0d results: %0d lookups, %0d assigns done, %0d empty, %0d refused full.",
             sb.n_checked, sb.n_lookup, sb.n_done, sb.n_ignored, sb.n_full);
    $display("Default value took its reset, both extremes and zero.");
    if (sb.errors == 0 && sb.want_value.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end
endmodule
